[rtl/core/swm_pkg.sv]
// Shared constants, command/status types and helpers for the sliding window maximum.
// Depends on nothing; used by the controller, the datapath and the top level.
package swm_pkg;

   // Deque storage depth and the widths that follow from it.
   localparam int MAX_WINDOW = 64;
   localparam int ADDR_W     = $clog2(MAX_WINDOW);
   localparam int CNT_W      = $clog2(MAX_WINDOW) + 1;
   localparam int POS_W      = CNT_W;

   // Field widths fixed by the interface.
   localparam int DATA_W = 32;
   localparam int WIN_W  = 7;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;      // take the input item
      logic rd_tail;    // read the tail entry
      logic rd_head;    // read the head entry
      logic pop_tail;   // drop the tail entry
      logic pop_head;   // drop the head entry
      logic head_keep;  // keep the head value just read
      logic append;     // write the sample and issue the result
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;      // deque holds no entries
      logic tail_le;    // read tail value is not greater than the sample
      logic head_old;   // read head entry has left the window
      logic out_free;   // result register can take a new item this cycle
   } status_type;

   // Ring buffer slot of an offset from the head, wrapped at the depth.
   function automatic logic [ADDR_W-1:0] slot(input logic [ADDR_W-1:0] head,
                                              input logic [CNT_W-1:0]  offset);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(head) + (CNT_W+1)'(offset);
      if (sum >= (CNT_W+1)'(MAX_WINDOW)) begin
         sum = sum - (CNT_W+1)'(MAX_WINDOW);
      end
      return ADDR_W'(sum);
   endfunction

endpackage

[rtl/core/swm_ctrl.sv]
// Sequencer of the sliding window maximum: tail pops, head pops, then append.
// Depends on swm_pkg for the command and status types.
module swm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  swm_pkg::status_type status,
   output swm_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_TAIL_REQ = 3'd1;
   localparam logic [2:0] ST_TAIL_CHK = 3'd2;
   localparam logic [2:0] ST_HEAD_REQ = 3'd3;
   localparam logic [2:0] ST_HEAD_CHK = 3'd4;
   localparam logic [2:0] ST_APPEND   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Only an idle sequencer takes a new item.
   assign req_stall = (state_ff != ST_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_TAIL_REQ;
            end
         end
         ST_TAIL_REQ: begin
            if (status.empty) begin
               state_in = ST_HEAD_REQ;
            end else begin
               cmd.rd_tail = 1'b1;
               state_in    = ST_TAIL_CHK;
            end
         end
         ST_TAIL_CHK: begin
            if (status.tail_le) begin
               cmd.pop_tail = 1'b1;
               state_in     = ST_TAIL_REQ;
            end else begin
               state_in = ST_HEAD_REQ;
            end
         end
         ST_HEAD_REQ: begin
            if (status.empty) begin
               state_in = ST_APPEND;
            end else begin
               cmd.rd_head = 1'b1;
               state_in    = ST_HEAD_CHK;
            end
         end
         ST_HEAD_CHK: begin
            if (status.head_old) begin
               cmd.pop_head = 1'b1;
               state_in     = ST_HEAD_REQ;
            end else begin
               cmd.head_keep = 1'b1;
               state_in      = ST_APPEND;
            end
         end
         ST_APPEND: begin
            if (status.out_free) begin
               cmd.append = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/swm_dp.sv]
// Datapath of the sliding window maximum: deque ring buffer, pointers and result register.
// Depends on swm_pkg for widths, the slot helper and the command and status types.
module swm_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic signed [swm_pkg::DATA_W-1:0] req_sample,
   input  logic                              req_sequence_start,
   input  logic                              csr_we,
   input  logic [swm_pkg::WIN_W-1:0]         csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [swm_pkg::DATA_W-1:0] rsp_window_max,
   input  swm_pkg::cmd_type                  cmd,
   output swm_pkg::status_type               status
);

   // Deque storage.
   logic signed [swm_pkg::DATA_W-1:0] cand_value_ff [swm_pkg::MAX_WINDOW];
   logic [swm_pkg::POS_W-1:0]         cand_pos_ff   [swm_pkg::MAX_WINDOW];

   logic [swm_pkg::WIN_W-1:0]         window_ff;
   logic [swm_pkg::ADDR_W-1:0]        head_ff, head_in;
   logic [swm_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [swm_pkg::POS_W-1:0]         pos_ff, pos_in;
   logic [swm_pkg::CNT_W-1:0]         seen_ff, seen_in;
   logic signed [swm_pkg::DATA_W-1:0] smp_ff;
   logic signed [swm_pkg::DATA_W-1:0] rd_value_ff;
   logic [swm_pkg::POS_W-1:0]         rd_pos_ff;
   logic signed [swm_pkg::DATA_W-1:0] head_val_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [swm_pkg::DATA_W-1:0] rsp_data_ff;

   logic [swm_pkg::CNT_W-1:0]         weff;
   logic [swm_pkg::ADDR_W-1:0]        rd_addr;
   logic [swm_pkg::ADDR_W-1:0]        wr_addr;
   logic [swm_pkg::POS_W-1:0]         age;
   logic                              produce;

   // Effective window: zero acts as one, large values saturate at the depth.
   always_comb begin
      if (window_ff == '0) begin
         weff = swm_pkg::CNT_W'(1);
      end else if (int'(window_ff) > swm_pkg::MAX_WINDOW) begin
         weff = swm_pkg::CNT_W'(swm_pkg::MAX_WINDOW);
      end else begin
         weff = swm_pkg::CNT_W'(window_ff);
      end
   end

   // Read address is the tail slot or the head slot; write goes past the tail.
   assign rd_addr = cmd.rd_tail ? swm_pkg::slot(head_ff, count_ff - swm_pkg::CNT_W'(1))
                                : head_ff;
   assign wr_addr = swm_pkg::slot(head_ff, count_ff);

   // Status toward the controller.
   assign age             = pos_ff - rd_pos_ff;
   assign status.empty    = (count_ff == '0);
   assign status.tail_le  = (rd_value_ff <= smp_ff);
   assign status.head_old = (age >= weff);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // A result leaves once the sequence holds a full window.
   assign produce = (((seen_ff < weff) ? seen_ff + swm_pkg::CNT_W'(1) : seen_ff) >= weff);

   // Pointer and counter updates.
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      seen_in  = seen_ff;
      if (cmd.start && req_sequence_start) begin
         head_in  = '0;
         count_in = '0;
         pos_in   = '0;
         seen_in  = '0;
      end
      if (cmd.pop_tail) begin
         count_in = count_ff - swm_pkg::CNT_W'(1);
      end
      if (cmd.pop_head) begin
         head_in  = swm_pkg::slot(head_ff, swm_pkg::CNT_W'(1));
         count_in = count_ff - swm_pkg::CNT_W'(1);
      end
      if (cmd.append) begin
         count_in = count_ff + swm_pkg::CNT_W'(1);
         pos_in   = pos_ff + swm_pkg::POS_W'(1);
         if (seen_ff < weff) begin
            seen_in = seen_ff + swm_pkg::CNT_W'(1);
         end
      end
   end

   // Result register handshake.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.append && produce) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= swm_pkg::WIN_W'(1);
         head_ff      <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            window_ff <= csr_wdata;
         end
         head_ff      <= head_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Deque memory with registered read.
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         cand_value_ff[wr_addr] <= smp_ff;
         cand_pos_ff[wr_addr]   <= pos_ff;
      end
      if (cmd.rd_tail || cmd.rd_head) begin
         rd_value_ff <= cand_value_ff[rd_addr];
         rd_pos_ff   <= cand_pos_ff[rd_addr];
      end
   end

   // Payload registers: sample, surviving head value and result.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         smp_ff <= req_sample;
      end
      if (cmd.head_keep) begin
         head_val_ff <= rd_value_ff;
      end
      if (cmd.append && produce) begin
         rsp_data_ff <= status.empty ? smp_ff : head_val_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_max = rsp_data_ff;

`ifndef SYNTH
   // The deque never holds more entries than the storage depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= swm_pkg::CNT_W'(swm_pkg::MAX_WINDOW))
      else $error("deque count beyond storage depth");

   // A tail pop is only issued on a non-empty deque.
   assert property (@(posedge clock) disable iff (reset)
      cmd.pop_tail |-> (count_ff != '0))
      else $error("tail pop on empty deque");

   // A new result only appears after an append.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.append))
      else $error("result without append");

   // An append never overwrites a result that is still stalled.
   assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> !(rsp_valid_ff && rsp_stall))
      else $error("append over a stalled result");
`endif

endmodule

[rtl/core/sliding_window_maximum_top.sv]
// Top level of the sliding window maximum: joins the sequencer and the datapath.
// Depends on swm_pkg, swm_ctrl and swm_dp.
//
//   channel   direction  handshake          payload
//   req       in         req_valid/stall    req_sample[31:0], req_sequence_start
//   rsp       out        rsp_valid/stall    rsp_window_max[31:0]
//   csr       in         csr_we             csr_wdata[6:0] (window size)
//
// Each accepted item first drops the tail entries that are not above it, then the head
// entries that have left the window, and is then appended; each check is one read
// of the deque memory plus one compare. A new item is taken only once the sequencer
// is idle. Reset is synchronous; it clears the pointers and sets the window to one.
// A stalled result holds its register; the next item is taken meanwhile and waits in
// its append step until the result register frees.
module sliding_window_maximum_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [swm_pkg::DATA_W-1:0] req_sample,
   input  logic                              req_sequence_start,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [swm_pkg::DATA_W-1:0] rsp_window_max,
   input  logic                              csr_we,
   input  logic [swm_pkg::WIN_W-1:0]         csr_wdata
);

   swm_pkg::cmd_type    cmd;
   swm_pkg::status_type status;

   // Sequencer.
   swm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   swm_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_sample         (req_sample),
      .req_sequence_start (req_sequence_start),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_window_max     (rsp_window_max),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the sliding window maximum block.
// Depends on swm_pkg and sliding_window_maximum_top; predicts every window maximum
// with its own monotonic deque and checks each result item in order.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 300;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 110;
   localparam int PHASES       = 10;
   localparam int CYCLE_LIMIT  = 1_000_000;

   // Shapes of the random sample runs.
   typedef enum int {
      SHAPE_NOISE,
      SHAPE_NARROW,
      SHAPE_FALLING,
      SHAPE_RISING,
      SHAPE_EXTREME
   } shape_type;

   // Keeps the expected window maxima from a deque of its own.
   class window_max_tracker;
      logic signed [swm_pkg::DATA_W-1:0] cand_value [swm_pkg::MAX_WINDOW];
      int unsigned                       cand_pos [swm_pkg::MAX_WINDOW];
      int unsigned                       head, fill, next_pos, seen;
      logic [swm_pkg::WIN_W-1:0]         window_reg;
      logic signed [swm_pkg::DATA_W-1:0] expected_max [$];
      int                                errors, checked;

      function new();
         head       = 0;
         fill       = 0;
         next_pos   = 0;
         seen       = 0;
         window_reg = swm_pkg::WIN_W'(1);
         errors     = 0;
         checked    = 0;
      endfunction

      function void set_window(logic [swm_pkg::WIN_W-1:0] value);
         window_reg = value;
      endfunction

      function void note_sample(logic signed [swm_pkg::DATA_W-1:0] value, logic restart);
         int unsigned span, pos;
         span = (window_reg == 0) ? 1 :
                (window_reg > swm_pkg::MAX_WINDOW) ? swm_pkg::MAX_WINDOW : window_reg;
         if (restart) begin
            head     = 0;
            fill     = 0;
            next_pos = 0;
            seen     = 0;
         end
         pos = next_pos;
         // Tail candidates not above the new sample can never be the maximum again.
         while (fill > 0 &&
                cand_value[(head + fill - 1) % swm_pkg::MAX_WINDOW] <= value) begin
            fill--;
         end
         // Head candidates that have fallen out of the window are retired.
         while (fill > 0 && pos - cand_pos[head] >= span) begin
            head = (head + 1) % swm_pkg::MAX_WINDOW;
            fill--;
         end
         if (fill >= swm_pkg::MAX_WINDOW) begin
            head = (head + 1) % swm_pkg::MAX_WINDOW;
            fill--;
         end
         cand_value[(head + fill) % swm_pkg::MAX_WINDOW] = value;
         cand_pos[(head + fill) % swm_pkg::MAX_WINDOW]   = pos;
         fill++;
         next_pos = pos + 1;
         if (seen < span) begin
            seen++;
         end
         // A full window yields its maximum, the head candidate.
         if (seen >= span) begin
            expected_max.insert(expected_max.size(), cand_value[head]);
         end
      endfunction

      function void check_max(logic signed [swm_pkg::DATA_W-1:0] got);
         logic signed [swm_pkg::DATA_W-1:0] want;
         if (expected_max.size() == 0) begin
            $error("window_max: expected nothing, actual %0d", got);
            errors++;
         end else begin
            want = expected_max[0];
            expected_max.delete(0);
            checked++;
            if (got !== want) begin
               $error("window_max: expected %0d, actual %0d", want, got);
               errors++;
            end
         end
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic signed [swm_pkg::DATA_W-1:0] req_sample;
   logic                              req_sequence_start;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic signed [swm_pkg::DATA_W-1:0] rsp_window_max;
   logic                              csr_we;
   logic [swm_pkg::WIN_W-1:0]         csr_wdata;

   logic                              hold_request = 1'b0;
   logic                              hold_done = 1'b0;
   logic                              rx_steady = 1'b0;
   int                                hold_left = 0;
   int                                cycles = 0;
   int                                samples_sent = 0;
   int                                windows_set = 0;
   logic [swm_pkg::WIN_W-1:0]         phase_windows [PHASES] = '{
      7'd64, 7'd1, 7'd64, 7'd0, 7'd127, 7'd17, 7'd2, 7'd65, 7'd33, 7'd5
   };

   window_max_tracker tracker;

   sliding_window_maximum_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .req_sequence_start (req_sequence_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_window_max     (rsp_window_max),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Result side stalls: random, a long hold-off once, none in the steady phase.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= !rx_steady && ($urandom_range(0, 99) < 33);
      end
   end

   // Every accepted result item is checked against the oldest expected maximum.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_max(rsp_window_max);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: timed out after %0d cycles", cycles);
         $display("tb: errors");
         $finish;
      end
   end

   // Offers one item, with random gaps unless steady, and waits for it to be taken.
   task automatic send_sample(input logic signed [swm_pkg::DATA_W-1:0] value,
                              input logic restart, input bit steady);
      while (!steady && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_sample         <= value;
      req_sequence_start <= restart;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      @(negedge clock);
      tracker.note_sample(value, restart);
      samples_sent++;
   endtask

   // Waits for every expected maximum, then lets a last resultless item retire.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tracker.expected_max.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_window(input logic [swm_pkg::WIN_W-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      tracker.set_window(value);
      windows_set++;
   endtask

   initial begin
      shape_type                         shape;
      int                                run_left;
      int                                ramp;
      bit                                steady;
      logic [swm_pkg::WIN_W-1:0]         span;
      logic signed [swm_pkg::DATA_W-1:0] value;
      logic                              restart;

      tracker            = new();
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_sample         = '0;
      req_sequence_start = 1'b0;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      shape              = SHAPE_NOISE;
      run_left           = 0;
      ramp               = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Window of one from reset, no sequence start: every sample is its own maximum.
      send_sample(32'sd0, 1'b0, 1'b0);
      send_sample(32'sh7FFF_FFFF, 1'b0, 1'b0);
      send_sample(32'sh8000_0000, 1'b0, 1'b0);
      send_sample(-32'sd1, 1'b0, 1'b0);

      // Equal samples, extremes, a restart mid-sequence and a falling run.
      write_window(7'd3);
      send_sample(32'sd5, 1'b1, 1'b0);
      send_sample(32'sd5, 1'b0, 1'b0);
      send_sample(32'sd7, 1'b0, 1'b0);
      send_sample(32'sh8000_0000, 1'b0, 1'b0);
      send_sample(32'sh8000_0000, 1'b0, 1'b0);
      send_sample(-32'sd1, 1'b0, 1'b0);
      send_sample(32'sd10, 1'b1, 1'b0);
      send_sample(32'sd9, 1'b0, 1'b0);
      send_sample(32'sd8, 1'b0, 1'b0);
      send_sample(32'sd7, 1'b0, 1'b0);

      // A zero window acts as one.
      write_window(7'd0);
      send_sample(32'sd3, 1'b0, 1'b0);
      send_sample(-32'sd3, 1'b0, 1'b0);

      // Oversized window saturates; then it shrinks and grows mid-sequence.
      write_window(7'd127);
      send_sample(32'sd1, 1'b1, 1'b0);
      send_sample(32'sd2, 1'b0, 1'b0);
      write_window(7'd2);
      send_sample(32'sd4, 1'b0, 1'b0);
      send_sample(32'sd1, 1'b0, 1'b0);
      send_sample(32'sd2, 1'b0, 1'b0);
      write_window(7'd5);
      send_sample(32'sd6, 1'b0, 1'b0);
      send_sample(32'sd1, 1'b0, 1'b0);

      // Random phases, each under its own window; odd phases open a new sequence.
      for (int phase = 0; phase < PHASES; phase++) begin
         span = (phase == PHASES - 1) ? swm_pkg::WIN_W'($urandom_range(1, 127))
                                      : phase_windows[phase];
         write_window(span);
         steady = (phase == 5);
         rx_steady <= steady;
         run_left = 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 2 && n == 30) begin
               hold_request <= 1'b1;
            end
            if (run_left == 0) begin
               shape    = shape_type'($urandom_range(0, 4));
               run_left = $urandom_range(5, 80);
               ramp     = $urandom;
            end
            run_left--;
            case (shape)
               SHAPE_NOISE: value = $urandom;
               SHAPE_NARROW: value = int'($urandom_range(0, 6)) - 3;
               SHAPE_FALLING: begin
                  ramp  = ramp - int'($urandom_range(0, 3));
                  value = ramp;
               end
               SHAPE_RISING: begin
                  ramp  = ramp + int'($urandom_range(0, 3));
                  value = ramp;
               end
               default: begin
                  case ($urandom_range(0, 3))
                     0: value = 32'sh8000_0000;
                     1: value = 32'sh7FFF_FFFF;
                     2: value = 32'sd0;
                     default: value = -32'sd1;
                  endcase
               end
            endcase
            restart = (n == 0 && phase[0]) || ($urandom_range(0, 149) == 0);
            send_sample(value, restart, steady);
         end
      end

      wait_idle();
      $display("tb: %0d samples under %0d window settings, %0d window maxima checked",
               samples_sent, windows_set, tracker.checked);
      if (tracker.errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
